[rtl/ppi_pkg.sv]
// package for the 8255 parallel port block: opcodes, port codes, payload structs
// no dependencies
`default_nettype none
package ppi_pkg;
    typedef enum logic [2:0] {
        OP_CPU_WRITE = 3'd0,
        OP_CPU_READ  = 3'd1,
        OP_PIN_BYTE  = 3'd2,
        OP_PIN_BIT   = 3'd3,
        OP_PIN_READ  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        PORT_A  = 2'd0,
        PORT_B  = 2'd1,
        PORT_C  = 2'd2,
        PORT_CW = 2'd3
    } port_t;

    localparam logic [7:0] CW_RESET = 8'h9B;

    typedef struct packed {
        logic [2:0] opcode;
        logic [1:0] port_select;
        logic [7:0] data_byte;
        logic [2:0] bit_index;
        logic       bit_level;
    } ppi_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       port_a_written;
        logic       port_b_written;
        logic       mode_written;
        logic       port_c_high_changed;
        logic       port_c_low_changed;
        logic       bad_port;
    } ppi_rsp_t;
endpackage
`default_nettype wire

[rtl/ppi_req_if.sv]
// valid/ready channel interfaces for access beats and result beats
// depends on ppi_pkg
`default_nettype none
interface ppi_req_if;
    logic valid;
    logic ready;
    ppi_pkg::ppi_req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ppi_rsp_if;
    logic valid;
    logic ready;
    ppi_pkg::ppi_rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/parallel_port_interface_8255_unit.sv]
// 8255-style programmable parallel port, one access per beat
// Channels: req (sink) carries one access beat: opcode, port_select,
// data_byte, bit_index, bit_level. rsp (source) carries one result beat per
// access: read_data and the write/change/bad_port flags.
// The result is registered, so it is offered in the cycle after the access is
// accepted. Throughput: one access per cycle while the receiver takes results;
// the whole update of the port registers is one combinational pass from current
// state and the beat to next state and result.
// Stall: the result register holds while rsp.ready is low; req.ready is
// high while the result register is empty or is taken this cycle, so a
// stalled receiver stops new accesses after exactly one pending result.
// Reset: control word 0x9B (all ports mode 0, input), output latches zero,
// pin buffers 0xFF, strobe latches and interrupt enables zero, no result
// pending.
// depends on ppi_pkg and the channel interfaces
`default_nettype none
module parallel_port_interface_8255_unit (
    input wire logic clk,
    input wire logic rst_n,
    ppi_req_if.sink  req,
    ppi_rsp_if.source rsp
);
    import ppi_pkg::*;

    logic [7:0] cw_reg, cw_next;
    logic [7:0] ola_reg, ola_next, olb_reg, olb_next, olc_reg, olc_next;
    logic [7:0] pba_reg, pba_next, pbb_reg, pbb_next, pbc_reg, pbc_next;
    logic [7:0] sla_reg, sla_next, slb_reg, slb_next;
    logic ena_in_reg, ena_in_next, ena_out_reg, ena_out_next, enb_reg, enb_next;
    logic rsp_valid_reg;
    ppi_rsp_t rsp_reg, rsp_next;

    logic accept;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept = req.valid && req.ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data = rsp_reg;

    // control word decodes
    logic cl_out0, cl_in0, ch_out0, ch_in0, gb1, ga2;
    logic [1:0] gam;
    logic [2:0] m70;
    assign cl_out0 = (cw_reg & 8'h05) == 8'h00;
    assign cl_in0  = (cw_reg & 8'h05) == 8'h01;
    assign ch_out0 = (cw_reg & 8'h68) == 8'h00;
    assign ch_in0  = (cw_reg & 8'h68) == 8'h08;
    assign gb1 = cw_reg[2];
    assign gam = cw_reg[6:5];
    assign ga2 = gam == 2'b10;
    assign m70 = cw_reg[6:4];

    // port C read as seen by the cpu
    logic [7:0] cpu_c;
    always_comb
    begin
        cpu_c = 8'h00;
        if (cl_out0) cpu_c[3:0] = olc_reg[3:0];
        else if (cl_in0) cpu_c[3:0] = pbc_reg[3:0];
        if (ch_out0) cpu_c[7:4] = olc_reg[7:4];
        else if (ch_in0) cpu_c[7:4] = pbc_reg[7:4];
        if (gam == 2'b01) begin
            if (cw_reg[4]) begin
                cpu_c = cpu_c & 8'hC7;
                cpu_c[4] = ena_in_reg;
                cpu_c[5] = olc_reg[5];
            end else begin
                cpu_c = cpu_c & 8'h37;
                cpu_c[6] = ena_out_reg;
                cpu_c[7] = olc_reg[7];
            end
            cpu_c[3] = olc_reg[3];
        end else if (ga2) begin
            cpu_c = (cpu_c & 8'h07) | (olc_reg & 8'hA8);
            cpu_c[4] = ena_in_reg;
            cpu_c[6] = ena_out_reg;
        end
        if (gb1) begin
            cpu_c = cpu_c & 8'hF8;
            cpu_c[2] = enb_reg;
            cpu_c[1:0] = olc_reg[1:0];
            if (gam == 2'b00) cpu_c[3] = cw_reg[3] ? pbc_reg[3] : olc_reg[3];
        end
    end

    // peripheral view of the pins
    logic [7:0] pin_rd;
    always_comb
    begin
        pin_rd = 8'h00;
        case (req.data.port_select)
            PORT_A:
            begin
                if (ga2) begin
                    if (!pbc_reg[6]) pin_rd = ola_reg;
                    else if (!pbc_reg[4]) pin_rd = pba_reg;
                    else pin_rd = 8'hFF;
                end else pin_rd = cw_reg[4] ? pba_reg : ola_reg;
            end
            PORT_B: pin_rd = cw_reg[1] ? pbb_reg : olb_reg;
            default:
            begin
                if (cl_out0) pin_rd[2:0] = olc_reg[2:0];
                else if (cl_in0) pin_rd[2:0] = pbc_reg[2:0];
                else pin_rd[2:0] = {pbc_reg[2], olc_reg[1:0]};
                if (ch_out0) pin_rd[7:4] = olc_reg[7:4];
                else if (ch_in0) pin_rd[7:4] = pbc_reg[7:4];
                else if (m70 == 3'b010) pin_rd = pin_rd | (olc_reg & 8'h88) | (pbc_reg & 8'h70);
                else if (m70 == 3'b011) pin_rd = pin_rd | (olc_reg & 8'h28) | (pbc_reg & 8'hD0);
                else if (ga2) pin_rd = pin_rd | (olc_reg & 8'hA8) | (pbc_reg & 8'h50);
                if (gam == 2'b00) begin
                    if (cl_out0) pin_rd[3] = olc_reg[3];
                    else if (cl_in0) pin_rd[3] = pbc_reg[3];
                end
            end
        endcase
    end

    // next state and result
    logic [7:0] d, bm, pin_val, c, mcw;
    logic [3:0] v;
    logic [2:0] sel_pos;
    logic inte, sel_a_in, sel_a_out, mgb1;
    always_comb
    begin
        cw_next = cw_reg; ola_next = ola_reg; olb_next = olb_reg;
        pba_next = pba_reg; pbb_next = pbb_reg; pbc_next = pbc_reg;
        sla_next = sla_reg; slb_next = slb_reg;
        ena_in_next = ena_in_reg; ena_out_next = ena_out_reg; enb_next = enb_reg;
        c = olc_reg;
        rsp_next = '0;
        d = req.data.data_byte;
        v = d[3:0];
        sel_pos = v[3:1];
        inte = 1'b0;
        mcw = d;
        if (d[6:5] == 2'b11) mcw[5] = 1'b0;
        mgb1 = mcw[2];
        bm = 8'h01 << req.data.bit_index;
        pin_val = req.data.port_select == PORT_A ? pba_reg :
                  req.data.port_select == PORT_B ? pbb_reg : pbc_reg;
        pin_val = (pin_val & ~bm) | (req.data.bit_level ? bm : 8'h00);
        if (req.data.opcode == OP_PIN_BYTE) pin_val = d;
        sel_a_in = (m70 == 3'b011 || ga2) && sel_pos == 3'd4;
        sel_a_out = !sel_a_in && (m70 == 3'b010 || ga2) && sel_pos == 3'd6;
        case (req.data.opcode)
            OP_CPU_WRITE:
            begin
                case (req.data.port_select)
                    PORT_A:
                    begin
                        ola_next = d;
                        if (gam == 2'b00) rsp_next.port_a_written = 1'b1;
                        else c = c & 8'h77;
                    end
                    PORT_B:
                    begin
                        olb_next = d;
                        if (!gb1) rsp_next.port_b_written = 1'b1;
                        else c = c & 8'hFC;
                    end
                    PORT_C:
                    begin
                        if (cl_out0) c[3:0] = d[3:0];
                        if (ch_out0) c[7:4] = d[7:4];
                    end
                    default:
                    begin
                        if (d[7]) begin
                            // mode set resets the port registers
                            cw_next = mcw;
                            pba_next = 8'hFF; ola_next = 8'h00;
                            pbb_next = 8'hFF; olb_next = 8'h00;
                            if (mgb1) slb_next = 8'h00;
                            pbc_next = 8'h00;
                            if (!mgb1) pbc_next = pbc_next | 8'h07;
                            if (mcw[6:5] == 2'b00) pbc_next = pbc_next | 8'hF8;
                            c = 8'h00;
                            c[1] = mgb1;
                            c[7] = mcw[6:5] != 2'b00;
                            ena_in_next = 1'b0; ena_out_next = 1'b0; enb_next = 1'b0;
                            rsp_next.mode_written = 1'b1;
                        end else begin
                            // port C bit set/reset
                            if (sel_a_in) ena_in_next = v[0];
                            if (sel_a_out) ena_out_next = v[0];
                            if (sel_a_in || sel_a_out) begin
                                inte = 1'b1;
                                c[3] = (ena_in_next && pbc_reg[4] && c[5]) ||
                                       (ena_out_next && pbc_reg[6] && c[7]);
                            end
                            if (gb1 && sel_pos == 3'd2) begin
                                enb_next = v[0];
                                c[0] = v[0] && pbc_reg[2] && c[1];
                                inte = 1'b1;
                            end
                            if (!inte && ((cl_out0 && ch_out0) ||
                                (cl_out0 && ch_in0 && sel_pos < 3'd4) ||
                                (cl_in0 && ch_out0 && sel_pos > 3'd3) ||
                                (cl_out0 && sel_pos < 3'd3) ||
                                (ch_out0 && sel_pos > 3'd2)))
                                c[sel_pos] = v[0];
                        end
                    end
                endcase
            end
            OP_CPU_READ:
            begin
                case (req.data.port_select)
                    PORT_A:
                    begin
                        if (m70 == 3'b001) rsp_next.read_data = pba_reg;
                        else if (m70 == 3'b000) rsp_next.read_data = ola_reg & pba_reg;
                        else if (m70 == 3'b010) rsp_next.read_data = ola_reg;
                        else begin
                            rsp_next.read_data = sla_reg;
                            c = c & 8'hD7;
                        end
                    end
                    PORT_B:
                    begin
                        if (cw_reg[2:1] == 2'b01) rsp_next.read_data = pbb_reg;
                        else if (cw_reg[2:1] == 2'b11) begin
                            rsp_next.read_data = slb_reg;
                            c = c & 8'hFC;
                        end else rsp_next.read_data = olb_reg;
                    end
                    PORT_C: rsp_next.read_data = cpu_c;
                    default: rsp_next.read_data = cw_reg;
                endcase
            end
            OP_PIN_BYTE, OP_PIN_BIT:
            begin
                case (req.data.port_select)
                    PORT_A: pba_next = pin_val;
                    PORT_B: pbb_next = pin_val;
                    PORT_C:
                    begin
                        // strobe / acknowledge edges on handshake pins
                        if (gb1) begin
                            if (pbc_reg[2] && !pin_val[2]) begin
                                if (cw_reg[1]) slb_next = pbb_reg;
                                c[1] = 1'b1;
                                c[0] = 1'b0;
                            end else if (!pbc_reg[2] && pin_val[2])
                                c[0] = enb_reg && c[1];
                        end
                        if (gam != 2'b00) begin
                            if (ga2 || m70 == 3'b011) begin
                                if (pbc_reg[4] && !pin_val[4]) begin
                                    sla_next = pba_reg;
                                    c[5] = 1'b1;
                                    c[3] = 1'b0;
                                end else if (!pbc_reg[4] && pin_val[4])
                                    c[3] = ena_in_reg && c[5];
                            end
                            if (ga2 || m70 == 3'b010) begin
                                if (pbc_reg[6] && !pin_val[6]) begin
                                    c[7] = 1'b1;
                                    c[3] = 1'b0;
                                end else if (!pbc_reg[6] && pin_val[6])
                                    c[3] = ena_out_reg && c[7];
                            end
                        end
                        pbc_next = pin_val;
                    end
                    default: rsp_next.bad_port = 1'b1;
                endcase
            end
            OP_PIN_READ:
            begin
                if (req.data.port_select == PORT_CW) begin
                    rsp_next.bad_port = 1'b1;
                    rsp_next.read_data = 8'hFF;
                end else rsp_next.read_data = pin_rd;
            end
            default: ;
        endcase
        olc_next = c;
        rsp_next.port_c_high_changed = rsp_next.mode_written || (c[7:4] != olc_reg[7:4]);
        rsp_next.port_c_low_changed = rsp_next.mode_written || (c[3:0] != olc_reg[3:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cw_reg <= CW_RESET;
            ola_reg <= 8'h00; olb_reg <= 8'h00; olc_reg <= 8'h00;
            pba_reg <= 8'hFF; pbb_reg <= 8'hFF; pbc_reg <= 8'hFF;
            sla_reg <= 8'h00; slb_reg <= 8'h00;
            ena_in_reg <= 1'b0; ena_out_reg <= 1'b0; enb_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                cw_reg <= cw_next;
                ola_reg <= ola_next; olb_reg <= olb_next; olc_reg <= olc_next;
                pba_reg <= pba_next; pbb_reg <= pbb_next; pbc_reg <= pbc_next;
                sla_reg <= sla_next; slb_reg <= slb_next;
                ena_in_reg <= ena_in_next; ena_out_reg <= ena_out_next;
                enb_reg <= enb_next;
                rsp_valid_reg <= 1'b1;
            end else if (rsp.ready) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) rsp_reg <= rsp_next;
    end

    // group A mode 3 is never stored
    a_no_mode3: assert property (@(posedge clk) disable iff (!rst_n)
        cw_reg[6:5] != 2'b11) else $error("group A mode 3 stored");
    // a stalled result holds and blocks input
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp.ready |=> rsp_valid_reg && $stable(rsp_reg))
        else $error("stalled result changed");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp.ready |-> !req.ready) else $error("ready while full");
    // mode set always flags both port C halves
    a_mode_flags: assert property (@(posedge clk) disable iff (!rst_n)
        accept && rsp_next.mode_written |-> rsp_next.port_c_high_changed &&
        rsp_next.port_c_low_changed) else $error("mode set flags");
endmodule
`default_nettype wire

[verif/tb_parallel_port_interface_8255_unit.sv]
// testbench for the 8255-style parallel port unit: directed and random access beats
// checked against a cycle-free predictor held in a small scoreboard class
// depends on ppi_pkg, ppi_req_if, ppi_rsp_if and parallel_port_interface_8255_unit
`timescale 1ns / 1ps

module tb_parallel_port_interface_8255_unit;
    import ppi_pkg::*;

    // opcodes above the defined set do nothing but must still answer with zeros
    localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;
    localparam int RANDOM_ACCESSES = 750;
    localparam int IDLE_LIMIT      = 500;
    localparam int LONG_HOLD       = 120;

    // port model with its own copy of every register, plus the queue of expected results
    class ppi_scoreboard;
        logic [7:0] cw;
        logic [7:0] lat_a, lat_b, lat_c;
        logic [7:0] pins_a, pins_b, pins_c;
        logic [7:0] stb_a, stb_b;
        bit         inte_a_in, inte_a_out, inte_b;
        ppi_rsp_t   pending_results[$];
        int         mismatches;

        function new();
            mismatches = 0;
            apply_mode(CW_RESET);
            stb_a = '0;
            stb_b = '0;
        endfunction

        function bit low_out();  return (cw & 8'h05) == 8'h00; endfunction
        function bit low_in();   return (cw & 8'h05) == 8'h01; endfunction
        function bit high_out(); return (cw & 8'h68) == 8'h00; endfunction
        function bit high_in();  return (cw & 8'h68) == 8'h08; endfunction
        function bit b_mode1();  return cw[2]; endfunction
        function logic [7:0] a_mode(); return cw & 8'h60; endfunction

        function void apply_mode(logic [7:0] v);
            logic [7:0] w;
            w = v;
            if (w[6:5] == 2'b11)
                w[5] = 1'b0;
            cw = w;
            pins_a = 8'hFF;
            lat_a = '0;
            pins_b = 8'hFF;
            if (b_mode1())
                stb_b = '0;
            lat_b = '0;
            pins_c = '0;
            if (!b_mode1())
                pins_c |= 8'h07;
            if (a_mode() == 0)
                pins_c |= 8'hF8;
            lat_c = '0;
            if (b_mode1())
                lat_c |= 8'h02;
            if (a_mode() != 0)
                lat_c |= 8'h80;
            inte_a_in = 0;
            inte_a_out = 0;
            inte_b = 0;
        endfunction

        function void bit_set_reset(logic [7:0] val);
            logic [3:0] v;
            logic [3:0] sel;
            logic [7:0] m;
            int         pos;
            bit         mode2;
            bit         enable_hit;
            v = val[3:0];
            sel = v & 4'hE;
            m = cw & 8'h70;
            pos = v >> 1;
            mode2 = a_mode() == 8'h40;
            enable_hit = 0;
            if ((m == 8'h30 || mode2) && sel == 8) begin
                inte_a_in = v[0];
                enable_hit = 1;
            end
            else if ((m == 8'h20 || mode2) && sel == 12) begin
                inte_a_out = v[0];
                enable_hit = 1;
            end
            if (enable_hit) begin
                lat_c &= 8'hF7;
                if ((inte_a_in && pins_c[4] && lat_c[5]) || (inte_a_out && pins_c[6] && lat_c[7]))
                    lat_c |= 8'h08;
            end
            if (b_mode1() && sel == 4) begin
                inte_b = v[0];
                lat_c &= 8'hFE;
                if (inte_b && pins_c[2] && lat_c[1])
                    lat_c |= 8'h01;
                enable_hit = 1;
            end
            if (!enable_hit) begin
                if ((low_out() && high_out()) || (low_out() && high_in() && pos < 4) ||
                    (low_in() && high_out() && pos > 3) || (low_out() && pos < 3) ||
                    (high_out() && pos > 2))
                    lat_c[pos] = v[0];
            end
        endfunction

        function logic [7:0] cpu_status_c();
            logic [7:0] r;
            r = '0;
            if (low_out())
                r |= lat_c & 8'h0F;
            else if (low_in())
                r |= pins_c & 8'h0F;
            if (high_out())
                r |= lat_c & 8'hF0;
            else if (high_in())
                r |= pins_c & 8'hF0;
            if (a_mode() == 8'h20) begin
                if (cw[4]) begin
                    r &= 8'hC7;
                    if (inte_a_in)
                        r |= 8'h10;
                    r |= lat_c & 8'h20;
                end
                else begin
                    r &= 8'h37;
                    if (inte_a_out)
                        r |= 8'h40;
                    r |= lat_c & 8'h80;
                end
                r |= lat_c & 8'h08;
            end
            else if (a_mode() == 8'h40) begin
                r &= 8'h07;
                if (inte_a_in)
                    r |= 8'h10;
                if (inte_a_out)
                    r |= 8'h40;
                r |= lat_c & 8'hA8;
            end
            if (b_mode1()) begin
                r &= 8'hF8;
                if (inte_b)
                    r |= 8'h04;
                r |= lat_c & 8'h03;
                if (a_mode() == 0) begin
                    r &= 8'hF7;
                    r |= cw[3] ? (pins_c & 8'h08) : (lat_c & 8'h08);
                end
            end
            return r;
        endfunction

        function void drive_pins_c(logic [7:0] val);
            logic [7:0] prev;
            logic [7:0] m;
            bit         mode2;
            prev = pins_c;
            if (b_mode1()) begin
                if (prev[2] && !val[2]) begin
                    if (cw[1])
                        stb_b = pins_b;
                    lat_c |= 8'h02;
                    lat_c &= 8'hFE;
                end
                else if (!prev[2] && val[2]) begin
                    if (inte_b && lat_c[1])
                        lat_c |= 8'h01;
                    else
                        lat_c &= 8'hFE;
                end
            end
            if (a_mode() != 0) begin
                mode2 = a_mode() == 8'h40;
                m = cw & 8'h70;
                if (mode2 || m == 8'h30) begin
                    if (prev[4] && !val[4]) begin
                        stb_a = pins_a;
                        lat_c |= 8'h20;
                        lat_c &= 8'hF7;
                    end
                    else if (!prev[4] && val[4]) begin
                        if (inte_a_in && lat_c[5])
                            lat_c |= 8'h08;
                        else
                            lat_c &= 8'hF7;
                    end
                end
                if (mode2 || m == 8'h20) begin
                    if (prev[6] && !val[6]) begin
                        lat_c |= 8'h80;
                        lat_c &= 8'hF7;
                    end
                    else if (!prev[6] && val[6]) begin
                        if (inte_a_out && lat_c[7])
                            lat_c |= 8'h08;
                        else
                            lat_c &= 8'hF7;
                    end
                end
            end
            pins_c = val;
        endfunction

        function logic [7:0] pin_view(port_t p);
            logic [7:0] r;
            logic [7:0] m;
            r = '0;
            if (p == PORT_A) begin
                if (a_mode() == 8'h40) begin
                    if (!pins_c[6])
                        r = lat_a;
                    else if (!pins_c[4])
                        r = pins_a;
                    else
                        r = 8'hFF;
                end
                else
                    r = cw[4] ? pins_a : lat_a;
            end
            else if (p == PORT_B)
                r = cw[1] ? pins_b : lat_b;
            else begin
                m = cw & 8'h70;
                if (low_out())
                    r |= lat_c & 8'h07;
                else if (low_in())
                    r |= pins_c & 8'h07;
                else
                    r |= (lat_c & 8'h03) | (pins_c & 8'h04);
                if (high_out())
                    r |= lat_c & 8'hF0;
                else if (high_in())
                    r |= pins_c & 8'hF0;
                else if (m == 8'h20)
                    r |= (lat_c & 8'h88) | (pins_c & 8'h70);
                else if (m == 8'h30)
                    r |= (lat_c & 8'h28) | (pins_c & 8'hD0);
                else if (a_mode() == 8'h40)
                    r |= (lat_c & 8'hA8) | (pins_c & 8'h50);
                if (a_mode() == 0) begin
                    if (low_out())
                        r |= lat_c & 8'h08;
                    else if (low_in())
                        r |= pins_c & 8'h08;
                end
            end
            return r;
        endfunction

        // advance the port model by one access and queue the result it should give
        function void note_access(ppi_req_t a);
            ppi_rsp_t   res;
            logic [7:0] latch_c_prev;
            logic [7:0] diff;
            logic [7:0] m;
            logic [7:0] mask;
            port_t      p;
            res = '0;
            latch_c_prev = lat_c;
            p = port_t'(a.port_select);
            case (a.opcode)
                OP_CPU_WRITE: begin
                    if (p == PORT_A) begin
                        lat_a = a.data_byte;
                        if (a_mode() == 0)
                            res.port_a_written = 1;
                        else
                            lat_c &= 8'h77;
                    end
                    else if (p == PORT_B) begin
                        lat_b = a.data_byte;
                        if (!b_mode1())
                            res.port_b_written = 1;
                        else
                            lat_c &= 8'hFC;
                    end
                    else if (p == PORT_C) begin
                        if (low_out() && high_out())
                            lat_c = a.data_byte;
                        else if (low_out())
                            lat_c = (lat_c & 8'hF0) | (a.data_byte & 8'h0F);
                        else if (high_out())
                            lat_c = (lat_c & 8'h0F) | (a.data_byte & 8'hF0);
                    end
                    else if (a.data_byte[7]) begin
                        apply_mode(a.data_byte);
                        res.mode_written = 1;
                    end
                    else
                        bit_set_reset(a.data_byte);
                end
                OP_CPU_READ: begin
                    if (p == PORT_A) begin
                        m = cw & 8'h70;
                        if (m == 8'h10)
                            res.read_data = pins_a;
                        else if (m == 8'h00)
                            res.read_data = lat_a & pins_a;
                        else if (m == 8'h20)
                            res.read_data = lat_a;
                        else begin
                            res.read_data = stb_a;
                            lat_c &= 8'hD7;
                        end
                    end
                    else if (p == PORT_B) begin
                        m = cw & 8'h06;
                        if (m == 8'h02)
                            res.read_data = pins_b;
                        else if (m == 8'h06) begin
                            res.read_data = stb_b;
                            lat_c &= 8'hFC;
                        end
                        else
                            res.read_data = lat_b;
                    end
                    else if (p == PORT_C)
                        res.read_data = cpu_status_c();
                    else
                        res.read_data = cw;
                end
                OP_PIN_BYTE, OP_PIN_BIT: begin
                    if (p == PORT_CW)
                        res.bad_port = 1;
                    else if (a.opcode == OP_PIN_BYTE) begin
                        if (p == PORT_A)
                            pins_a = a.data_byte;
                        else if (p == PORT_B)
                            pins_b = a.data_byte;
                        else
                            drive_pins_c(a.data_byte);
                    end
                    else begin
                        mask = 8'h01 << a.bit_index;
                        if (p == PORT_A)
                            pins_a = (pins_a & ~mask) | (a.bit_level ? mask : 8'h00);
                        else if (p == PORT_B)
                            pins_b = (pins_b & ~mask) | (a.bit_level ? mask : 8'h00);
                        else
                            drive_pins_c((pins_c & ~mask) | (a.bit_level ? mask : 8'h00));
                    end
                end
                OP_PIN_READ: begin
                    if (p == PORT_CW) begin
                        res.bad_port = 1;
                        res.read_data = 8'hFF;
                    end
                    else
                        res.read_data = pin_view(p);
                end
                default: ;
            endcase
            diff = res.mode_written ? 8'hFF : (latch_c_prev ^ lat_c);
            res.port_c_high_changed = |diff[7:4];
            res.port_c_low_changed = |diff[3:0];
            pending_results.push_back(res);
        endfunction

        function void report_mismatch(string field, logic [7:0] got, logic [7:0] want);
            $display("mismatch at %0t: %s got %h expected %h", $time, field, got, want);
            mismatches++;
        endfunction

        function void check_result(ppi_rsp_t got);
            ppi_rsp_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", 8'(got), 8'h00);
                return;
            end
            want = pending_results.pop_front();
            if (got.read_data !== want.read_data)
                report_mismatch("read_data", got.read_data, want.read_data);
            if (got.port_a_written !== want.port_a_written)
                report_mismatch("port_a_written", 8'(got.port_a_written), 8'(want.port_a_written));
            if (got.port_b_written !== want.port_b_written)
                report_mismatch("port_b_written", 8'(got.port_b_written), 8'(want.port_b_written));
            if (got.mode_written !== want.mode_written)
                report_mismatch("mode_written", 8'(got.mode_written), 8'(want.mode_written));
            if (got.port_c_high_changed !== want.port_c_high_changed)
                report_mismatch("port_c_high_changed", 8'(got.port_c_high_changed),
                                8'(want.port_c_high_changed));
            if (got.port_c_low_changed !== want.port_c_low_changed)
                report_mismatch("port_c_low_changed", 8'(got.port_c_low_changed),
                                8'(want.port_c_low_changed));
            if (got.bad_port !== want.bad_port)
                report_mismatch("bad_port", 8'(got.bad_port), 8'(want.bad_port));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ppi_req_if req_if ();
    ppi_rsp_if rsp_if ();

    parallel_port_interface_8255_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    ppi_scoreboard port_model;
    bit            long_hold_req;
    int            idle_cycles;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // gap length: mostly none, some short, a few long
    function int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one access beat and hold it until the unit takes it
    task automatic send_access(ppi_req_t a);
        int gap;
        req_if.valid = 1'b1;
        req_if.data = a;
        do
            @(posedge clk);
        while (!req_if.ready);
        port_model.note_access(a);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_fields(logic [2:0] op, port_t p, logic [7:0] d,
                               logic [2:0] idx = '0, logic lvl = 1'b0);
        ppi_req_t a;
        a.opcode = op;
        a.port_select = p;
        a.data_byte = d;
        a.bit_index = idx;
        a.bit_level = lvl;
        send_access(a);
    endtask

    // one random access, weighted toward mode sets, enables and handshake pin edges
    task automatic send_random_access();
        ppi_req_t a;
        int       roll;
        logic [2:0] hs_pins[3];
        hs_pins[0] = 3'd2;
        hs_pins[1] = 3'd4;
        hs_pins[2] = 3'd6;
        a = ppi_req_t'($bits(ppi_req_t)'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < 6)
        begin
            a.opcode = OP_CPU_WRITE;
            a.port_select = PORT_CW;
            a.data_byte[7] = 1'b1;
        end
        else if (roll < 18)
        begin
            a.opcode = OP_CPU_WRITE;
            a.port_select = PORT_CW;
            a.data_byte[7] = 1'b0;
        end
        else if (roll < 46)
        begin
            a.opcode = OP_PIN_BIT;
            a.port_select = PORT_C;
            if ($urandom_range(0, 3) != 0)
                a.bit_index = hs_pins[$urandom_range(0, 2)];
        end
        else if (roll < 56)
        begin
            a.opcode = OP_PIN_BYTE;
        end
        else if (roll < 60)
        begin
            a.opcode = OP_PIN_BIT;
        end
        else if (roll < 78)
        begin
            a.opcode = OP_CPU_READ;
        end
        else if (roll < 88)
        begin
            a.opcode = OP_CPU_WRITE;
            a.port_select = port_t'($urandom_range(0, 2));
        end
        else if (roll < 96)
        begin
            a.opcode = OP_PIN_READ;
        end
        else
        begin
            a.opcode = 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
        end
        send_access(a);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        int roll;
        rsp_if.ready = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                rsp_if.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_if.ready = 1'b1;
                roll = $urandom_range(0, 99);
                if (roll < 25)
                    stall_left = $urandom_range(1, 3);
                else if (roll < 28)
                    stall_left = $urandom_range(8, 30);
            end
        end
    end

    // result checking at the rising edge
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
                port_model.check_result(rsp_if.data);
        end
    end

    // watchdog: too many cycles without any beat on either channel
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_parallel_port_interface_8255_unit: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        port_model = new();
        long_hold_req = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset state: control word, port C read, port A pin view
        send_fields(OP_CPU_READ, PORT_CW, 8'h00);
        send_fields(OP_CPU_READ, PORT_C, 8'h00);
        send_fields(OP_PIN_READ, PORT_A, 8'h00);
        // all outputs in mode 0, write every port, bit set on C7
        send_fields(OP_CPU_WRITE, PORT_CW, 8'h80);
        send_fields(OP_CPU_WRITE, PORT_A, 8'hFF);
        send_fields(OP_CPU_WRITE, PORT_B, 8'h00);
        send_fields(OP_CPU_WRITE, PORT_C, 8'hA5);
        send_fields(OP_CPU_WRITE, PORT_CW, 8'h0F);
        send_fields(OP_PIN_READ, PORT_C, 8'h00);
        // group A mode 3 stored as mode 2, everything input, group B mode 1
        send_fields(OP_CPU_WRITE, PORT_CW, 8'hFF);
        send_fields(OP_CPU_READ, PORT_CW, 8'h00);
        send_fields(OP_PIN_BYTE, PORT_A, 8'h3C);
        send_fields(OP_CPU_WRITE, PORT_CW, 8'h09);
        send_fields(OP_CPU_WRITE, PORT_CW, 8'h05);
        send_fields(OP_PIN_BIT, PORT_C, 8'h00, 3'd4, 1'b0);
        send_fields(OP_PIN_BIT, PORT_C, 8'h00, 3'd4, 1'b1);
        send_fields(OP_PIN_BIT, PORT_C, 8'h00, 3'd2, 1'b0);
        send_fields(OP_PIN_BIT, PORT_C, 8'h00, 3'd2, 1'b1);
        send_fields(OP_CPU_READ, PORT_C, 8'h00);
        send_fields(OP_CPU_READ, PORT_A, 8'h00);
        send_fields(OP_CPU_READ, PORT_B, 8'h00);
        // group A mode 1 output with acknowledge on C6
        send_fields(OP_CPU_WRITE, PORT_CW, 8'hA0);
        send_fields(OP_CPU_WRITE, PORT_A, 8'h5A);
        send_fields(OP_PIN_BIT, PORT_C, 8'h00, 3'd6, 1'b0);
        // peripheral access to the control word, then an unused opcode
        send_fields(OP_PIN_BYTE, PORT_CW, 8'hFF, 3'd7, 1'b1);
        send_fields(OP_PIN_READ, PORT_CW, 8'h00);
        send_fields(OP_RESERVED_LAST, PORT_CW, 8'hFF, 3'd7, 1'b1);

        // sender pauses until every result of the directed part is in
        req_if.valid = 1'b0;
        while (port_model.pending_results.size() != 0)
            @(negedge clk);

        for (int n = 0; n < RANDOM_ACCESSES; n++)
        begin
            // long receiver hold-off while the sender keeps offering beats
            if (n == RANDOM_ACCESSES / 3)
                long_hold_req = 1'b1;
            send_random_access();
        end
        req_if.valid = 1'b0;

        while (port_model.pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);

        if (port_model.mismatches == 0)
            $display("tb_parallel_port_interface_8255_unit: PASS");
        else
            $display("tb_parallel_port_interface_8255_unit: FAIL");
        $finish;
    end
endmodule

[sim.f]
rtl/ppi_pkg.sv
rtl/ppi_req_if.sv
rtl/parallel_port_interface_8255_unit.sv
verif/tb_parallel_port_interface_8255_unit.sv
